// ----- design/bsfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types and constants of the byte-stuffed frame decoder.
// ----------------------------------------------------------------------------
package bsfd_pkg;

    localparam logic [7:0] MARK_START = 8'h40;  // '@'
    localparam logic [7:0] MARK_END   = 8'h23;  // '#'
    localparam logic [7:0] MARK_ESC   = 8'h2A;  // '*'
    localparam logic [7:0] ESC_STAR   = 8'h30;  // '0'
    localparam logic [7:0] ESC_HASH   = 8'h31;  // '1'

    localparam int unsigned LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam int unsigned PADDR_W = 3;
    localparam logic REG_FRAME_LIMIT = 1'b0;

    typedef struct packed {
        logic [7:0] value;
        logic       is_start;
        logic       is_end;
    } token_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_DATA,
        ST_ESC,
        ST_EMPTY
    } back_state_t;

endpackage

// ----- design/bsfd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_queue
// Two-entry queue of classified tokens between front and back.
// ----------------------------------------------------------------------------
module bsfd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bsfd_pkg::token_t push_tok,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output bsfd_pkg::token_t pop_tok
);
    import bsfd_pkg::*;

    token_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_tok   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ----- design/bsfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_front
// Accepts received bytes, tags frame markers and queues them for the back.
// ----------------------------------------------------------------------------
module bsfd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             tok_pop,
    output logic             tok_valid,
    output bsfd_pkg::token_t tok
);
    import bsfd_pkg::*;

    token_t in_tok;
    logic   q_full;
    logic   q_push;

    always_comb begin
        in_tok.value    = s_rx_byte;
        in_tok.is_start = (s_rx_byte == MARK_START);
        in_tok.is_end   = (s_rx_byte == MARK_END);
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    bsfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_tok  (in_tok),
        .full      (q_full),
        .pop       (tok_pop),
        .not_empty (tok_valid),
        .pop_tok   (tok)
    );

endmodule

// ----- design/bsfd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_back
// Frame engine: tracks frame mode, fills the frame store and emits results.
// ----------------------------------------------------------------------------
module bsfd_back #(
    parameter int unsigned STORE_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [bsfd_pkg::LIMIT_W-1:0] frame_limit,
    input  logic                         tok_valid,
    input  bsfd_pkg::token_t             tok,
    output logic                         tok_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_command,
    output logic [7:0]                   m_data_byte,
    output logic                         m_has_data,
    output logic                         m_last
);
    import bsfd_pkg::*;

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned FW = $clog2(STORE_DEPTH + 1);

    back_state_t state_reg, state_next;
    logic          in_frame_reg, in_frame_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [7:0]    cmd_reg, cmd_next;

    logic [7:0]    store_mem [STORE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr;

    logic          out_valid_reg;
    logic [7:0]    out_cmd_reg, out_data_reg;
    logic          out_has_reg, out_last_reg;

    logic          out_free;
    logic          emit;
    logic [7:0]    res_data;
    logic          res_has;
    logic          res_last;
    logic [FW-1:0] idx_inc;
    logic          fill_full;

    assign out_free  = !out_valid_reg || m_ready;
    assign idx_inc   = idx_reg + 1'b1;
    // Effective limit is the smaller of the register and the store depth.
    assign fill_full = (LIMIT_W'(fill_reg) >= frame_limit)
                    || (fill_reg == FW'(STORE_DEPTH));

    always_comb begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        tok_pop       = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = idx_inc[AW-1:0];
        emit          = 1'b0;
        res_data      = 8'd0;
        res_has       = 1'b1;
        res_last      = (idx_inc >= fill_reg);

        case (state_reg)
            ST_IDLE: begin
                if (tok_valid) begin
                    tok_pop = 1'b1;
                    if (!in_frame_reg) begin
                        if (tok.is_start) begin
                            in_frame_next = 1'b1;
                        end
                    end else if (tok.is_end) begin
                        in_frame_next = 1'b0;
                        if (fill_reg != '0) begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_CMD;
                        end
                    end else if (fill_full) begin
                        // Overflow drops the whole frame silently.
                        in_frame_next = 1'b0;
                        fill_next     = '0;
                    end else begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_CMD: begin
                cmd_next = rd_data_reg;
                if (fill_reg == FW'(1)) begin
                    state_next = ST_EMPTY;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(1);
                    idx_next   = FW'(1);
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (rd_data_reg == MARK_ESC && idx_inc < fill_reg) begin
                    rd_en      = 1'b1;
                    idx_next   = idx_inc;
                    state_next = ST_ESC;
                end else if (out_free) begin
                    emit     = 1'b1;
                    // A lone escape at the frame end decodes as a start marker.
                    res_data = (rd_data_reg == MARK_ESC) ? MARK_START : rd_data_reg;
                    idx_next = idx_inc;
                    if (res_last) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_ESC: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (rd_data_reg == ESC_STAR) begin
                        res_data = MARK_ESC;
                    end else if (rd_data_reg == ESC_HASH) begin
                        res_data = MARK_END;
                    end else begin
                        res_data = MARK_START;
                    end
                    idx_next = idx_inc;
                    if (res_last) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = ST_DATA;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    res_has    = 1'b0;
                    res_last   = 1'b1;
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_frame_reg  <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (emit) begin
            out_cmd_reg  <= cmd_reg;
            out_data_reg <= res_data;
            out_has_reg  <= res_has;
            out_last_reg <= res_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[fill_reg[AW-1:0]] <= tok.value;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_command   = out_cmd_reg;
    assign m_data_byte = out_data_reg;
    assign m_has_data  = out_has_reg;
    assign m_last      = out_last_reg;

endmodule

// ----- design/byte_stuffed_frame_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_core
// Decodes '@'...'#' framed, '*'-escaped byte streams into command/data items.
// ----------------------------------------------------------------------------
// The frame engine takes received bytes while idle; a two-entry queue in
// front of it keeps accepting bytes while a frame is being emitted. On the
// end marker the engine reads the frame store (one read port, registered
// data): it fetches the command, then emits one payload result per DATA
// step plus an ESC step per escape pair, or one EMPTY step for an empty
// payload. Results wait in an output register, so the engine stalls only
// when that register is full. frame_limit is written at APB addresses 0-3.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder_core #(
    parameter int unsigned STORE_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_command,
    output logic [7:0]                   m_data_byte,
    output logic                         m_has_data,
    output logic                         m_last
);
    import bsfd_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic               reg_sel;
    token_t             tok;
    logic               tok_valid;
    logic               tok_pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_FRAME_LIMIT);
    assign prdata  = reg_sel ? {{(32 - LIMIT_W){1'b0}}, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    bsfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .tok_pop   (tok_pop),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    bsfd_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_limit (limit_reg),
        .tok_valid   (tok_valid),
        .tok         (tok),
        .tok_pop     (tok_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_command   (m_command),
        .m_data_byte (m_data_byte),
        .m_has_data  (m_has_data),
        .m_last      (m_last)
    );

endmodule

// ----- design/bsfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_checker
// Port-level checks on the result channel of the frame decoder.
// ----------------------------------------------------------------------------
module bsfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_command,
    input logic [7:0] m_data_byte,
    input logic       m_has_data,
    input logic       m_last
);

    // No result may be pending in the cycle after a reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command)
            && $stable(m_data_byte) && $stable(m_has_data) && $stable(m_last))
        else $error("stalled result changed");

    // An empty payload is always the single, final item of its frame.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> m_last)
        else $error("empty-payload item not marked last");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> m_data_byte == 8'd0)
        else $error("empty-payload item carries data");

endmodule

bind byte_stuffed_frame_decoder_core bsfd_checker u_bsfd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_command   (m_command),
    .m_data_byte (m_data_byte),
    .m_has_data  (m_has_data),
    .m_last      (m_last)
);
